/* rtl/core/laht_pkg.sv */
// Shared types and constants of the link activity health tracker.
package laht_pkg;

    // Sizes
    localparam int NUM_LINKS = 2;
    localparam int LINK_W    = 1;
    localparam int CNT_W     = 32;
    localparam int LIMIT_W   = 8;

    localparam logic [CNT_W-1:0]   AGE_MAX     = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

    // Item kinds
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_DIRTY = 1'b1;

    // Health modes
    localparam logic [1:0] HM_DISABLED = 2'd0;
    localparam logic [1:0] HM_ACTIVE   = 2'd1;
    localparam logic [1:0] HM_FALLBACK = 2'd2;

    // Reason codes
    localparam logic [1:0] RSN_DISCONNECTED = 2'd0;
    localparam logic [1:0] RSN_HEALTHY      = 2'd1;
    localparam logic [1:0] RSN_STALE        = 2'd2;
    localparam logic [1:0] RSN_FALLBACK     = 2'd3;

    // One input word as held in the input register
    typedef struct packed {
        logic              mode;
        logic [LINK_W-1:0] link_index;
        logic [1:0]        health_mode;
        logic              link_connected;
        logic [CNT_W-1:0]  rx_chunk_count;
        logic [CNT_W-1:0]  tx_chunk_count;
        logic [CNT_W-1:0]  status_poll_count;
        logic [CNT_W-1:0]  tx_error_count;
        logic [CNT_W-1:0]  rx_error_count;
    } t_in_word;

    // Per-link tracking state
    typedef struct packed {
        logic             seen_before;
        logic [CNT_W-1:0] last_rx_chunks;
        logic [CNT_W-1:0] last_tx_chunks;
        logic [CNT_W-1:0] last_status_polls;
        logic [CNT_W-1:0] last_tx_errors;
        logic [CNT_W-1:0] last_rx_errors;
        logic [CNT_W-1:0] activity_age;
        logic [CNT_W-1:0] rx_age;
        logic [CNT_W-1:0] tx_age;
        logic             has_published;
        logic             published_available;
        logic [CNT_W-1:0] published_age;
        logic [1:0]       published_reason;
    } t_link_state;

    // One result word
    typedef struct packed {
        logic [LINK_W-1:0] out_link;
        logic              available;
        logic [1:0]        reason;
        logic [CNT_W-1:0]  activity_age;
        logic [CNT_W-1:0]  rx_age;
        logic [CNT_W-1:0]  tx_age;
        logic              error_growth;
        logic              connected_out;
        logic              publish;
    } t_out_word;

    // Evaluation outcome handed from the datapath to the control
    typedef struct packed {
        logic        res_valid;
        logic        wr_en;
        t_link_state next_state;
        t_out_word   result;
    } t_eval;

endpackage

/* rtl/core/laht_if.sv */
// Channel interfaces of the link activity health tracker.
interface laht_in_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [laht_pkg::LINK_W-1:0]     link_index;
    logic [1:0]                      health_mode;
    logic                            link_connected;
    logic [laht_pkg::CNT_W-1:0]      rx_chunk_count;
    logic [laht_pkg::CNT_W-1:0]      tx_chunk_count;
    logic [laht_pkg::CNT_W-1:0]      status_poll_count;
    logic [laht_pkg::CNT_W-1:0]      tx_error_count;
    logic [laht_pkg::CNT_W-1:0]      rx_error_count;

    modport source (
        output valid, mode, link_index, health_mode, link_connected, rx_chunk_count,
               tx_chunk_count, status_poll_count, tx_error_count, rx_error_count,
        input  ready
    );
    modport sink (
        input  valid, mode, link_index, health_mode, link_connected, rx_chunk_count,
               tx_chunk_count, status_poll_count, tx_error_count, rx_error_count,
        output ready
    );
endinterface

interface laht_out_if;
    logic                            valid;
    logic                            ready;
    logic [laht_pkg::LINK_W-1:0]     out_link;
    logic                            available;
    logic [1:0]                      reason;
    logic [laht_pkg::CNT_W-1:0]      activity_age;
    logic [laht_pkg::CNT_W-1:0]      rx_age;
    logic [laht_pkg::CNT_W-1:0]      tx_age;
    logic                            error_growth;
    logic                            connected_out;
    logic                            publish;

    modport source (
        output valid, out_link, available, reason, activity_age, rx_age, tx_age,
               error_growth, connected_out, publish,
        input  ready
    );
    modport sink (
        input  valid, out_link, available, reason, activity_age, rx_age, tx_age,
               error_growth, connected_out, publish,
        output ready
    );
endinterface

interface laht_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [laht_pkg::LIMIT_W-1:0]    healthy_age_limit;

    modport source (output valid, healthy_age_limit, input ready);
    modport sink   (input valid, healthy_age_limit, output ready);
endinterface

/* rtl/core/laht_state.sv */
// Per-link state registers with one read port and one write port.
module laht_state (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [laht_pkg::LINK_W-1:0]  i_rd_link,
    output laht_pkg::t_link_state        o_rd_state,
    input  logic                         i_wr_en,
    input  logic [laht_pkg::LINK_W-1:0]  i_wr_link,
    input  laht_pkg::t_link_state        i_wr_state
);

    laht_pkg::t_link_state r_state [laht_pkg::NUM_LINKS];

    // Read the addressed link; an out-of-range index reads as zero
    always_comb begin
        o_rd_state = '0;
        for (int k = 0; k < laht_pkg::NUM_LINKS; k++) begin
            if (int'(i_rd_link) == k) begin
                o_rd_state = r_state[k];
            end
        end
    end

    // Write back the updated link
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < laht_pkg::NUM_LINKS; k++) begin
                r_state[k] <= '0;
            end
        end else begin
            for (int k = 0; k < laht_pkg::NUM_LINKS; k++) begin
                if (i_wr_en && int'(i_wr_link) == k) begin
                    r_state[k] <= i_wr_state;
                end
            end
        end
    end

endmodule

/* rtl/core/laht_eval.sv */
// Single-pass evaluation of one word against its link's state.
module laht_eval (
    input  laht_pkg::t_in_word              i_word,
    input  laht_pkg::t_link_state           i_state,
    input  logic [laht_pkg::LIMIT_W-1:0]    i_limit,
    output laht_pkg::t_eval                 o_eval
);

    function automatic logic [laht_pkg::CNT_W-1:0] age_next(
        input logic [laht_pkg::CNT_W-1:0] age,
        input logic                       hit
    );
        logic [laht_pkg::CNT_W-1:0] res;
        if (hit) begin
            res = '0;
        end else if (age == laht_pkg::AGE_MAX) begin
            res = age;
        end else begin
            res = age + laht_pkg::CNT_W'(1);
        end
        return res;
    endfunction

    logic                         in_range;
    logic                         init;
    logic                         rx_hit;
    logic                         tx_hit;
    logic                         poll_hit;
    logic                         any_hit;
    logic                         err_growth;
    logic [laht_pkg::CNT_W-1:0]   act_age;
    logic [laht_pkg::CNT_W-1:0]   rx_age;
    logic [laht_pkg::CNT_W-1:0]   tx_age;
    logic                         avail;
    logic [1:0]                   reason;
    logic                         pub;
    laht_pkg::t_link_state        upd;

    assign in_range = int'(i_word.link_index) < laht_pkg::NUM_LINKS;

    // Growth detection; a wrapped counter does not count as activity
    assign init     = i_state.seen_before;
    assign rx_hit   = init && (i_word.rx_chunk_count > i_state.last_rx_chunks);
    assign tx_hit   = init && (i_word.tx_chunk_count > i_state.last_tx_chunks);
    assign poll_hit = init && (i_word.status_poll_count > i_state.last_status_polls);
    assign any_hit  = (!init && i_word.link_connected) || rx_hit || tx_hit || poll_hit;
    assign err_growth = init && (i_word.health_mode == laht_pkg::HM_ACTIVE) &&
                        ((i_word.tx_error_count > i_state.last_tx_errors) ||
                         (i_word.rx_error_count > i_state.last_rx_errors));

    // Saturating ages, cleared on the first tick of a link
    assign act_age = init ? age_next(i_state.activity_age, any_hit) : '0;
    assign rx_age  = init ? age_next(i_state.rx_age, rx_hit) : '0;
    assign tx_age  = init ? age_next(i_state.tx_age, tx_hit) : '0;

    // Availability and reason
    always_comb begin
        case (i_word.health_mode)
            laht_pkg::HM_ACTIVE: begin
                if (!i_word.link_connected) begin
                    avail  = 1'b0;
                    reason = laht_pkg::RSN_DISCONNECTED;
                end else if (act_age <= laht_pkg::CNT_W'(i_limit)) begin
                    avail  = 1'b1;
                    reason = laht_pkg::RSN_HEALTHY;
                end else begin
                    avail  = 1'b0;
                    reason = laht_pkg::RSN_STALE;
                end
            end
            laht_pkg::HM_FALLBACK: begin
                avail  = i_word.link_connected;
                reason = i_word.link_connected ? laht_pkg::RSN_FALLBACK
                                               : laht_pkg::RSN_DISCONNECTED;
            end
            default: begin
                avail  = 1'b0;
                reason = laht_pkg::RSN_DISCONNECTED;
            end
        endcase
    end

    // Publish when the view moved or nothing is published
    assign pub = !i_state.has_published ||
                 (avail != i_state.published_available) ||
                 (act_age != i_state.published_age) ||
                 (reason != i_state.published_reason);

    // Next link state
    always_comb begin
        upd = i_state;
        if (i_word.mode == laht_pkg::MODE_DIRTY) begin
            upd.has_published = 1'b0;
        end else begin
            upd.seen_before       = 1'b1;
            upd.last_rx_chunks    = i_word.rx_chunk_count;
            upd.last_tx_chunks    = i_word.tx_chunk_count;
            upd.last_status_polls = i_word.status_poll_count;
            upd.last_tx_errors    = i_word.tx_error_count;
            upd.last_rx_errors    = i_word.rx_error_count;
            upd.activity_age      = act_age;
            upd.rx_age            = rx_age;
            upd.tx_age            = tx_age;
            if (pub) begin
                upd.has_published       = 1'b1;
                upd.published_available = avail;
                upd.published_age       = act_age;
                upd.published_reason    = reason;
            end
        end
    end

    always_comb begin
        o_eval.wr_en                = in_range;
        o_eval.res_valid            = in_range && (i_word.mode == laht_pkg::MODE_TICK);
        o_eval.next_state           = upd;
        o_eval.result.out_link      = i_word.link_index;
        o_eval.result.available     = avail;
        o_eval.result.reason        = reason;
        o_eval.result.activity_age  = act_age;
        o_eval.result.rx_age        = rx_age;
        o_eval.result.tx_age        = tx_age;
        o_eval.result.error_growth  = err_growth;
        o_eval.result.connected_out = i_word.link_connected;
        o_eval.result.publish       = pub;
    end

endmodule

/* rtl/core/link_activity_health_tracker.sv */
// Top level of the link activity health tracker.
//
//  Channel   Dir  Handshake      Word
//  i_in      in   valid/ready    tick or dirty mark for one link, five 32-bit counters
//  o_out     out  valid/ready    availability, reason, three ages, flags, per tick
//  i_cfg     in   valid/ready    healthy_age_limit, always ready
//
//  One word per cycle while no result stalls: input register, one evaluation
//  pass, result register. Each result is registered as the pipeline advances.
//  Dirty marks update state and produce no result.
//  A stalled result holds the pipeline; input ready drops only when both
//  registers are full and the result is not taken.
//  Synchronous active-low reset clears all link state; limit resets to 1.
module link_activity_health_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    laht_in_if.sink     i_in,
    laht_out_if.source  o_out,
    laht_cfg_if.sink    i_cfg
);

    logic                            r_in_valid;
    laht_pkg::t_in_word              r_in;
    logic                            r_out_valid;
    laht_pkg::t_out_word             r_out;
    logic [laht_pkg::LIMIT_W-1:0]    r_limit;

    logic                            adv;
    logic                            in_acc;
    laht_pkg::t_link_state           rd_state;
    laht_pkg::t_eval                 ev;
    laht_pkg::t_in_word              in_word;

    // Pipeline control
    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || adv;
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign in_word.mode              = i_in.mode;
    assign in_word.link_index        = i_in.link_index;
    assign in_word.health_mode       = i_in.health_mode;
    assign in_word.link_connected    = i_in.link_connected;
    assign in_word.rx_chunk_count    = i_in.rx_chunk_count;
    assign in_word.tx_chunk_count    = i_in.tx_chunk_count;
    assign in_word.status_poll_count = i_in.status_poll_count;
    assign in_word.tx_error_count    = i_in.tx_error_count;
    assign in_word.rx_error_count    = i_in.rx_error_count;

    laht_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_link  (r_in.link_index),
        .o_rd_state (rd_state),
        .i_wr_en    (r_in_valid && adv && ev.wr_en),
        .i_wr_link  (r_in.link_index),
        .i_wr_state (ev.next_state)
    );

    laht_eval u_eval (
        .i_word  (r_in),
        .i_state (rd_state),
        .i_limit (r_limit),
        .o_eval  (ev)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= laht_pkg::LIMIT_RESET;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && ev.res_valid;
            end
            if (i_cfg.valid) begin
                r_limit <= i_cfg.healthy_age_limit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= in_word;
        end
        if (adv) begin
            r_out <= ev.result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_link      = r_out.out_link;
    assign o_out.available     = r_out.available;
    assign o_out.reason        = r_out.reason;
    assign o_out.activity_age  = r_out.activity_age;
    assign o_out.rx_age        = r_out.rx_age;
    assign o_out.tx_age        = r_out.tx_age;
    assign o_out.error_growth  = r_out.error_growth;
    assign o_out.connected_out = r_out.connected_out;
    assign o_out.publish       = r_out.publish;

endmodule

/* rtl/core/laht_checker.sv */
// Port-level checks of the link activity health tracker, bound to the top level.
module laht_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_available,
    input logic [1:0]                   i_reason,
    input logic                         i_connected_out,
    input logic [laht_pkg::CNT_W-1:0]   i_activity_age,
    input logic [laht_pkg::CNT_W-1:0]   i_rx_age,
    input logic [laht_pkg::CNT_W-1:0]   i_tx_age
);

    // A stalled result word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // Available exactly for healthy or fallback reasons
    a_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_available == ((i_reason == laht_pkg::RSN_HEALTHY) ||
                                         (i_reason == laht_pkg::RSN_FALLBACK))))
        else $error("availability disagrees with reason");

    // A disconnected link always reports the disconnected reason
    a_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_connected_out |-> i_reason == laht_pkg::RSN_DISCONNECTED)
        else $error("disconnected link with non-disconnected reason");

    // Fresh rx or tx activity also clears the activity age
    a_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_rx_age == '0) || (i_tx_age == '0)) |-> i_activity_age == '0)
        else $error("activity age not cleared by rx or tx growth");

    // Reset empties the result register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind link_activity_health_tracker laht_checker u_laht_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_available     (o_out.available),
    .i_reason        (o_out.reason),
    .i_connected_out (o_out.connected_out),
    .i_activity_age  (o_out.activity_age),
    .i_rx_age        (o_out.rx_age),
    .i_tx_age        (o_out.tx_age)
);

/* verif/tb_top.sv */
// Self-checking testbench for the link activity health tracker.
`timescale 1ns / 100ps

module tb_top;
    import laht_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int MAX_REPORTS    = 10;

    // Health mode code the block treats as disabled
    localparam logic [1:0]       HM_UNUSED = 2'd3;
    localparam logic [CNT_W-1:0] CNT_TOP   = '1;

    // Predicts the per-link view and checks each result word against it
    class link_view_scoreboard;
        t_link_state        links [NUM_LINKS];
        logic [LIMIT_W-1:0] age_limit;
        t_out_word          pending_views [$];
        int                 errors;

        function new();
            foreach (links[i]) links[i] = '0;
            age_limit = LIMIT_RESET;
            errors    = 0;
        endfunction

        // Saturating tick age
        function logic [CNT_W-1:0] next_age(logic [CNT_W-1:0] age, logic hit);
            if (hit) return '0;
            return (age == AGE_MAX) ? age : age + CNT_W'(1);
        endfunction

        // Update link state for one accepted input word, queue the view it yields
        function void track_word(t_in_word w);
            t_link_state s;
            t_out_word   v;
            logic        rx_hit, tx_hit, poll_hit, any_hit;
            if (w.link_index >= NUM_LINKS) return;
            if (w.mode == MODE_DIRTY) begin
                links[w.link_index].has_published = 1'b0;
                return;
            end
            s = links[w.link_index];
            // only growth counts as activity, so a wrap is ignored
            rx_hit   = s.seen_before && (w.rx_chunk_count > s.last_rx_chunks);
            tx_hit   = s.seen_before && (w.tx_chunk_count > s.last_tx_chunks);
            poll_hit = s.seen_before && (w.status_poll_count > s.last_status_polls);
            any_hit  = (!s.seen_before && w.link_connected) || rx_hit || tx_hit || poll_hit;

            v = '0;
            v.out_link      = w.link_index;
            v.connected_out = w.link_connected;
            v.error_growth  = s.seen_before && (w.health_mode == HM_ACTIVE) &&
                              ((w.tx_error_count > s.last_tx_errors) ||
                               (w.rx_error_count > s.last_rx_errors));

            if (!s.seen_before) begin
                s.activity_age = '0;
                s.rx_age       = '0;
                s.tx_age       = '0;
            end else begin
                s.activity_age = next_age(s.activity_age, any_hit);
                s.rx_age       = next_age(s.rx_age, rx_hit);
                s.tx_age       = next_age(s.tx_age, tx_hit);
            end
            v.activity_age = s.activity_age;
            v.rx_age       = s.rx_age;
            v.tx_age       = s.tx_age;

            // availability and reason
            case (w.health_mode)
                HM_ACTIVE: begin
                    if (!w.link_connected) begin
                        v.available = 1'b0;
                        v.reason    = RSN_DISCONNECTED;
                    end else if (s.activity_age <= CNT_W'(age_limit)) begin
                        v.available = 1'b1;
                        v.reason    = RSN_HEALTHY;
                    end else begin
                        v.available = 1'b0;
                        v.reason    = RSN_STALE;
                    end
                end
                HM_FALLBACK: begin
                    v.available = w.link_connected;
                    v.reason    = w.link_connected ? RSN_FALLBACK : RSN_DISCONNECTED;
                end
                default: begin
                    v.available = 1'b0;
                    v.reason    = RSN_DISCONNECTED;
                end
            endcase

            s.last_rx_chunks    = w.rx_chunk_count;
            s.last_tx_chunks    = w.tx_chunk_count;
            s.last_status_polls = w.status_poll_count;
            s.last_tx_errors    = w.tx_error_count;
            s.last_rx_errors    = w.rx_error_count;
            s.seen_before       = 1'b1;

            // publish when the view moved or none is held, as on a first tick or after a dirty mark
            v.publish = !s.has_published || (v.available != s.published_available) ||
                        (v.activity_age != s.published_age) ||
                        (v.reason != s.published_reason);
            if (v.publish) begin
                s.published_available = v.available;
                s.published_age       = v.activity_age;
                s.published_reason    = v.reason;
                s.has_published       = 1'b1;
            end

            links[w.link_index] = s;
            pending_views.push_back(v);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch on %s: expected %0h, got %0h",
                             $time, name, want, got);
            end
        endfunction

        // Check one result word against the oldest pending view
        function void check_view(t_out_word got);
            t_out_word want;
            if (pending_views.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result word with no pending view, link %0d",
                             $time, got.out_link);
                return;
            end
            want = pending_views.pop_front();
            compare_field("out_link", CNT_W'(want.out_link), CNT_W'(got.out_link));
            compare_field("available", CNT_W'(want.available), CNT_W'(got.available));
            compare_field("reason", CNT_W'(want.reason), CNT_W'(got.reason));
            compare_field("activity_age", want.activity_age, got.activity_age);
            compare_field("rx_age", want.rx_age, got.rx_age);
            compare_field("tx_age", want.tx_age, got.tx_age);
            compare_field("error_growth", CNT_W'(want.error_growth),
                          CNT_W'(got.error_growth));
            compare_field("connected_out", CNT_W'(want.connected_out),
                          CNT_W'(got.connected_out));
            compare_field("publish", CNT_W'(want.publish), CNT_W'(got.publish));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    laht_in_if  in_ch ();
    laht_out_if out_ch ();
    laht_cfg_if cfg_ch ();

    link_activity_health_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    link_view_scoreboard sb = new();

    int               snd_idle_pct;
    int               rcv_stall_pct;
    int               stuck_cycles;
    logic [CNT_W-1:0] drv_cnt [NUM_LINKS][5];

    always #5 i_clk = ~i_clk;

    // Output backpressure
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // Handshake monitor: results are checked before new words are noted
    always @(posedge i_clk) begin
        t_out_word got;
        t_in_word  seen;
        logic      moved;
        moved = 1'b0;
        if (out_ch.valid && out_ch.ready) begin
            got = '{out_link: out_ch.out_link, available: out_ch.available,
                    reason: out_ch.reason, activity_age: out_ch.activity_age,
                    rx_age: out_ch.rx_age, tx_age: out_ch.tx_age,
                    error_growth: out_ch.error_growth,
                    connected_out: out_ch.connected_out, publish: out_ch.publish};
            sb.check_view(got);
            moved = 1'b1;
        end
        if (cfg_ch.valid && cfg_ch.ready) begin
            sb.age_limit = cfg_ch.healthy_age_limit;
            moved = 1'b1;
        end
        if (in_ch.valid && in_ch.ready) begin
            seen = '{mode: in_ch.mode, link_index: in_ch.link_index,
                     health_mode: in_ch.health_mode, link_connected: in_ch.link_connected,
                     rx_chunk_count: in_ch.rx_chunk_count,
                     tx_chunk_count: in_ch.tx_chunk_count,
                     status_poll_count: in_ch.status_poll_count,
                     tx_error_count: in_ch.tx_error_count,
                     rx_error_count: in_ch.rx_error_count};
            sb.track_word(seen);
            moved = 1'b1;
        end
        stuck_cycles <= moved ? 0 : stuck_cycles + 1;
    end

    // Watchdog: too long without any handshake
    initial begin
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    function automatic t_in_word make_word(logic mode, logic [LINK_W-1:0] link,
                                           logic [1:0] hm, logic conn,
                                           logic [CNT_W-1:0] rx, logic [CNT_W-1:0] tx,
                                           logic [CNT_W-1:0] polls,
                                           logic [CNT_W-1:0] txe, logic [CNT_W-1:0] rxe);
        return '{mode: mode, link_index: link, health_mode: hm, link_connected: conn,
                 rx_chunk_count: rx, tx_chunk_count: tx, status_poll_count: polls,
                 tx_error_count: txe, rx_error_count: rxe};
    endfunction

    // Random word: per-link counters creep upward at grow_pct, with jumps and wraps as noise
    function automatic t_in_word random_word(int grow_pct, int noise_pct);
        t_in_word         w;
        int               r;
        logic [CNT_W-1:0] cnt [5];
        w.mode       = ($urandom_range(99) < 5) ? MODE_DIRTY : MODE_TICK;
        w.link_index = LINK_W'($urandom_range(NUM_LINKS - 1));
        r = $urandom_range(99);
        w.health_mode = (r < 70) ? HM_ACTIVE : (r < 80) ? HM_DISABLED :
                        (r < 90) ? HM_FALLBACK : HM_UNUSED;
        w.link_connected = ($urandom_range(99) < 85);
        for (int k = 0; k < 5; k++) begin
            if (w.mode == MODE_DIRTY) begin
                cnt[k] = $urandom;
            end else begin
                cnt[k] = drv_cnt[w.link_index][k];
                r = $urandom_range(99);
                if (r < grow_pct)
                    cnt[k] = cnt[k] + $urandom_range(1, 3);
                else if (r < grow_pct + noise_pct)
                    cnt[k] = $urandom_range(1) ? $urandom : CNT_TOP - $urandom_range(2);
                drv_cnt[w.link_index][k] = cnt[k];
            end
        end
        w.rx_chunk_count    = cnt[0];
        w.tx_chunk_count    = cnt[1];
        w.status_poll_count = cnt[2];
        w.tx_error_count    = cnt[3];
        w.rx_error_count    = cnt[4];
        return w;
    endfunction

    // Present one input word after random idle cycles; returns at a falling edge
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.mode              <= w.mode;
        in_ch.link_index        <= w.link_index;
        in_ch.health_mode       <= w.health_mode;
        in_ch.link_connected    <= w.link_connected;
        in_ch.rx_chunk_count    <= w.rx_chunk_count;
        in_ch.tx_chunk_count    <= w.tx_chunk_count;
        in_ch.status_poll_count <= w.status_poll_count;
        in_ch.tx_error_count    <= w.tx_error_count;
        in_ch.rx_error_count    <= w.rx_error_count;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Wait for the block to drain, then write the age limit
    task automatic set_limit(logic [LIMIT_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (sb.pending_views.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_ch.valid             <= 1'b1;
        cfg_ch.healthy_age_limit <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(int n, int snd, int rcv, int grow_pct, int noise_pct);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        repeat (n) send_word(random_word(grow_pct, noise_pct));
    endtask

    initial begin
        i_rst_n                  = 1'b0;
        in_ch.valid              = 1'b0;
        in_ch.mode               = MODE_TICK;
        in_ch.link_index         = '0;
        in_ch.health_mode        = HM_DISABLED;
        in_ch.link_connected     = 1'b0;
        in_ch.rx_chunk_count     = '0;
        in_ch.tx_chunk_count     = '0;
        in_ch.status_poll_count  = '0;
        in_ch.tx_error_count     = '0;
        in_ch.rx_error_count     = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.healthy_age_limit = LIMIT_RESET;
        out_ch.ready             = 1'b0;
        snd_idle_pct             = 0;
        rcv_stall_pct            = 0;
        foreach (drv_cnt[l, k]) drv_cnt[l][k] = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset limit, no idling
        // first tick of each link, one disconnected, one at counter maximum
        send_word(make_word(MODE_TICK, 1'b0, HM_ACTIVE, 1'b0, 0, 0, 0, 0, 0));
        send_word(make_word(MODE_TICK, 1'b1, HM_FALLBACK, 1'b1,
                            CNT_TOP, CNT_TOP, CNT_TOP, CNT_TOP, CNT_TOP));
        // healthy, then aging past the limit into stale
        send_word(make_word(MODE_TICK, 1'b0, HM_ACTIVE, 1'b1, 1, 0, 0, 0, 0));
        send_word(make_word(MODE_TICK, 1'b0, HM_ACTIVE, 1'b1, 1, 0, 0, 0, 0));
        send_word(make_word(MODE_TICK, 1'b0, HM_ACTIVE, 1'b1, 1, 0, 0, 0, 0));
        // error growth on each error counter
        send_word(make_word(MODE_TICK, 1'b0, HM_ACTIVE, 1'b1, 1, 5, 0, 1, 0));
        send_word(make_word(MODE_TICK, 1'b0, HM_ACTIVE, 1'b1, 1, 5, 1, 1, 1));
        // same view again: no publish
        send_word(make_word(MODE_TICK, 1'b0, HM_ACTIVE, 1'b1, 1, 5, 2, 1, 1));
        // counter wrap is not activity
        send_word(make_word(MODE_TICK, 1'b1, HM_FALLBACK, 1'b1, 0, 0, 0, 0, 0));
        send_word(make_word(MODE_TICK, 1'b1, HM_FALLBACK, 1'b0, 0, 0, 0, 0, 0));
        // unused and disabled health modes
        send_word(make_word(MODE_TICK, 1'b1, HM_UNUSED, 1'b1, 0, 0, 0, 0, 0));
        send_word(make_word(MODE_TICK, 1'b1, HM_DISABLED, 1'b1, 1, 0, 0, 0, 0));
        // dirty mark forces the next publish
        send_word(make_word(MODE_DIRTY, 1'b0, HM_UNUSED, 1'b1,
                            CNT_TOP, CNT_TOP, CNT_TOP, CNT_TOP, CNT_TOP));
        send_word(make_word(MODE_TICK, 1'b0, HM_ACTIVE, 1'b1, 1, 5, 3, 1, 1));
        send_word(make_word(MODE_TICK, 1'b0, HM_ACTIVE, 1'b1, 1, 5, 4, 1, 1));
        send_word(make_word(MODE_DIRTY, 1'b1, HM_UNUSED, 1'b0, 0, 0, 0, 0, 0));
        // error counters at maximum, then wrapping back
        send_word(make_word(MODE_TICK, 1'b1, HM_ACTIVE, 1'b1, 2, 0, 0, CNT_TOP, CNT_TOP));
        send_word(make_word(MODE_TICK, 1'b1, HM_ACTIVE, 1'b1, 2, 0, 0, 0, 0));
        send_word(make_word(MODE_TICK, 1'b0, HM_ACTIVE, 1'b1,
                            CNT_TOP, CNT_TOP, CNT_TOP, CNT_TOP, CNT_TOP));
        send_word(make_word(MODE_TICK, 1'b0, HM_DISABLED, 1'b0, 0, 0, 0, 0, 0));

        // Random phases over several limits and idling patterns
        set_limit('0);
        run_phase(250, 86, 0, 30, 5);
        // counters frozen so ages climb past the largest limit
        set_limit('1);
        run_phase(700, 8, 8, 0, 0);
        set_limit(LIMIT_W'($urandom_range(1, 20)));
        run_phase(350, 0, 86, 25, 5);
        set_limit(LIMIT_W'($urandom));
        run_phase(300, 0, 0, 10, 3);
        set_limit(LIMIT_W'($urandom_range(1, 4)));
        run_phase(280, 0, 0, 40, 10);
        in_ch.valid <= 1'b0;

        // Drain and let any stray result show up
        while (sb.pending_views.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/laht_pkg.sv
rtl/core/laht_if.sv
rtl/core/laht_state.sv
rtl/core/laht_eval.sv
rtl/core/link_activity_health_tracker.sv
rtl/core/laht_checker.sv
verif/tb_top.sv
